// ----- rtl/asm_operand_lexer_top_assert.svh -----
// Assertion macros for the operand lexer checker.
`ifndef ASM_OPERAND_LEXER_TOP_ASSERT_SVH
`define ASM_OPERAND_LEXER_TOP_ASSERT_SVH

// Same-cycle implication.
`define AOL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("operand lexer check failed");

// Next-cycle implication.
`define AOL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("operand lexer check failed");

`endif

// ----- rtl/aol_pkg.sv -----
`timescale 1ns / 1ps

package aol_pkg;

   typedef enum logic [2:0] {
      MODE_NONE  = 3'd0,
      MODE_IDENT = 3'd1,
      MODE_REG   = 3'd2,
      MODE_TFLAG = 3'd3,
      MODE_NUM   = 3'd4,
      MODE_STR   = 3'd5
   } mode_type;

   localparam logic [1:0] KIND_APPEND    = 2'd0;
   localparam logic [1:0] KIND_TOKEN_END = 2'd1;
   localparam logic [1:0] KIND_PARAM_END = 2'd2;
   localparam logic [1:0] KIND_STMT_END  = 2'd3;

   localparam logic [2:0] CLASS_NONE = 3'd0;
   localparam logic [2:0] CLASS_STR  = 3'd4;
   localparam logic [2:0] CLASS_OP   = 3'd5;

   // Event slots of one character, in emission order.
   localparam int SLOT_TOK_A  = 0;
   localparam int SLOT_APPEND = 1;
   localparam int SLOT_OP_END = 2;
   localparam int SLOT_PARAM  = 3;
   localparam int SLOT_TOK_B  = 4;
   localparam int SLOT_FPARAM = 5;
   localparam int SLOT_STMT   = 6;
   localparam int NUM_SLOTS   = 7;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [7:0]           ch;
      logic [2:0]           cls_a;
      logic [2:0]           cls_b;
   } bundle_type;

endpackage

// ----- rtl/aol_front.sv -----
`timescale 1ns / 1ps

module aol_front #(
   parameter int DEPTH_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          ch,
   input  logic                last,
   output aol_pkg::bundle_type bundle,
   output logic                push
);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_UP_X   = 8'h58;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic continues(input aol_pkg::mode_type m, input logic [7:0] c);
      logic r;
      r = 1'b0;
      unique case (m)
         aol_pkg::MODE_IDENT: r = c == CH_DOT || c == CH_UNDER || is_digit(c) || is_alpha(c);
         aol_pkg::MODE_REG:   r = c == CH_PCT || is_digit(c) || is_alpha(c);
         aol_pkg::MODE_TFLAG: r = c == CH_AT || is_digit(c) || is_alpha(c);
         aol_pkg::MODE_NUM:   r = c == CH_LOW_X || c == CH_UP_X || is_hex(c);
         default:             r = 1'b0;
      endcase
      return r;
   endfunction

   aol_pkg::mode_type     mode_ff, mode_in;
   logic                  esc_ff, esc_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                  has_ff, has_in;
   logic                  fresh;
   logic [aol_pkg::NUM_SLOTS-1:0] mask;
   logic [2:0]            cls_a, cls_b;

   always_comb begin
      mask     = '0;
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      depth_in = depth_ff;
      has_in   = has_ff;
      cls_a    = aol_pkg::CLASS_NONE;
      cls_b    = aol_pkg::CLASS_NONE;
      fresh    = 1'b0;

      case (mode_ff) inside
         aol_pkg::MODE_IDENT, aol_pkg::MODE_REG, aol_pkg::MODE_TFLAG,
         aol_pkg::MODE_NUM: begin
            if (continues(mode_ff, ch)) begin
               mask[aol_pkg::SLOT_APPEND] = 1'b1;
            end else begin
               mask[aol_pkg::SLOT_TOK_A] = 1'b1;
               cls_a   = 3'(mode_ff) - 3'd1;
               has_in  = 1'b1;
               mode_in = aol_pkg::MODE_NONE;
               esc_in  = 1'b0;
               fresh   = 1'b1;
            end
         end
         aol_pkg::MODE_STR: begin
            if (ch == CH_QUOTE && !esc_ff) begin
               mask[aol_pkg::SLOT_TOK_A] = 1'b1;
               cls_a   = aol_pkg::CLASS_STR;
               has_in  = 1'b1;
               mode_in = aol_pkg::MODE_NONE;
               esc_in  = 1'b0;
            end else begin
               esc_in = !esc_ff && ch == CH_BSLASH;
               mask[aol_pkg::SLOT_APPEND] = 1'b1;
            end
         end
         default: begin
            mode_in = aol_pkg::MODE_NONE;
            fresh   = 1'b1;
         end
      endcase

      if (fresh) begin
         if (ch == CH_SPACE || ch == CH_TAB) begin
            mask = mask;
         end else if (ch == CH_COMMA) begin
            if (depth_ff != '0) begin
               mask[aol_pkg::SLOT_APPEND] = 1'b1;
               mask[aol_pkg::SLOT_OP_END] = 1'b1;
               has_in = 1'b1;
            end else begin
               mask[aol_pkg::SLOT_PARAM] = 1'b1;
               has_in = 1'b0;
            end
         end else if (ch == CH_LPAREN || ch == CH_RPAREN || ch == CH_PLUS ||
                      ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH ||
                      ch == CH_COLON) begin
            if (ch == CH_LPAREN && depth_ff != '1) begin
               depth_in = depth_ff + DEPTH_BITS'(1);
            end else if (ch == CH_RPAREN && depth_ff != '0) begin
               depth_in = depth_ff - DEPTH_BITS'(1);
            end
            mask[aol_pkg::SLOT_APPEND] = 1'b1;
            mask[aol_pkg::SLOT_OP_END] = 1'b1;
            has_in = 1'b1;
         end else if (ch == CH_DOT || ch == CH_UNDER || is_alpha(ch)) begin
            mode_in = aol_pkg::MODE_IDENT;
            mask[aol_pkg::SLOT_APPEND] = 1'b1;
         end else if (ch == CH_PCT) begin
            mode_in = aol_pkg::MODE_REG;
            mask[aol_pkg::SLOT_APPEND] = 1'b1;
         end else if (ch == CH_DOLLAR || is_digit(ch)) begin
            mode_in = aol_pkg::MODE_NUM;
            mask[aol_pkg::SLOT_APPEND] = 1'b1;
         end else if (ch == CH_AT) begin
            mode_in = aol_pkg::MODE_TFLAG;
            mask[aol_pkg::SLOT_APPEND] = 1'b1;
         end else if (ch == CH_QUOTE) begin
            mode_in = aol_pkg::MODE_STR;
            esc_in  = 1'b0;
         end
      end

      if (last) begin
         if (mode_in != aol_pkg::MODE_NONE) begin
            mask[aol_pkg::SLOT_TOK_B] = 1'b1;
            cls_b  = 3'(mode_in) - 3'd1;
            has_in = 1'b1;
         end
         mask[aol_pkg::SLOT_FPARAM] = has_in;
         mask[aol_pkg::SLOT_STMT]   = 1'b1;
         mode_in  = aol_pkg::MODE_NONE;
         esc_in   = 1'b0;
         depth_in = '0;
         has_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= aol_pkg::MODE_NONE;
         esc_ff   <= 1'b0;
         depth_ff <= '0;
         has_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         esc_ff   <= esc_in;
         depth_ff <= depth_in;
         has_ff   <= has_in;
      end
   end

   assign bundle.mask  = mask;
   assign bundle.ch    = ch;
   assign bundle.cls_a = cls_a;
   assign bundle.cls_b = cls_b;
   assign push         = accept && (mask != '0);

endmodule

// ----- rtl/aol_queue.sv -----
`timescale 1ns / 1ps

module aol_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  aol_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output aol_pkg::bundle_type head_data
);

   aol_pkg::bundle_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_data  = entry_ff[rd_ptr_ff];

endmodule

// ----- rtl/aol_back.sv -----
`timescale 1ns / 1ps

module aol_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  aol_pkg::bundle_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_data_char,
   output logic [2:0]          rsp_token_class,
   output logic                rsp_run_last
);

   aol_pkg::bundle_type           cur_ff, cur_in;
   logic                          cur_valid_ff, cur_valid_in;
   logic                          valid_ff, valid_in;
   logic [1:0]                    kind_ff, kind_in;
   logic [7:0]                    char_ff, char_in;
   logic [2:0]                    class_ff, class_in;
   logic                          run_last_ff, run_last_in;
   logic [aol_pkg::NUM_SLOTS-1:0] low, rest;
   logic                          out_free, emit, done;

   always_comb begin
      low      = cur_ff.mask & (~cur_ff.mask + 1'b1);
      rest     = cur_ff.mask & ~low;
      out_free = !valid_ff || !rsp_stall;
      emit     = cur_valid_ff && out_free;
      done     = emit && (rest == '0);
      pop      = head_valid && (!cur_valid_ff || done);

      cur_in = cur_ff;
      if (pop) begin
         cur_in = head_data;
      end else if (emit) begin
         cur_in.mask = rest;
      end
      cur_valid_in = pop ? 1'b1 : (done ? 1'b0 : cur_valid_ff);
      valid_in     = emit ? 1'b1 : (out_free ? 1'b0 : valid_ff);

      kind_in     = aol_pkg::KIND_STMT_END;
      char_in     = 8'd0;
      class_in    = aol_pkg::CLASS_NONE;
      run_last_in = rest == '0;
      if (low[aol_pkg::SLOT_TOK_A]) begin
         kind_in  = aol_pkg::KIND_TOKEN_END;
         class_in = cur_ff.cls_a;
      end else if (low[aol_pkg::SLOT_APPEND]) begin
         kind_in = aol_pkg::KIND_APPEND;
         char_in = cur_ff.ch;
      end else if (low[aol_pkg::SLOT_OP_END]) begin
         kind_in  = aol_pkg::KIND_TOKEN_END;
         class_in = aol_pkg::CLASS_OP;
      end else if (low[aol_pkg::SLOT_PARAM] || low[aol_pkg::SLOT_FPARAM]) begin
         kind_in = aol_pkg::KIND_PARAM_END;
      end else if (low[aol_pkg::SLOT_TOK_B]) begin
         kind_in  = aol_pkg::KIND_TOKEN_END;
         class_in = cur_ff.cls_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         kind_ff     <= kind_in;
         char_ff     <= char_in;
         class_ff    <= class_in;
         run_last_ff <= run_last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_data_char   = char_ff;
   assign rsp_token_class = class_ff;
   assign rsp_run_last    = run_last_ff;

endmodule

// ----- rtl/asm_operand_lexer_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   ch[7:0], last
// rsp_      out        rsp_valid/rsp_stall   kind[1:0], data_char[7:0],
//                                            token_class[2:0], run_last
//
// One character is accepted per cycle while the two-entry event queue has room.
// Each character yields 0 to 5 events; the serializer sends one event per cycle while
// rsp_stall is low, and characters keep being accepted while earlier events drain.
// Each event passes the queue, the current-bundle register and the output register.
// Synchronous reset returns the lexer to no open token, depth 0.
// rsp_stall holds the output register; req_stall rises only when the queue is full.

module asm_operand_lexer_top #(
   parameter int DEPTH_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_char,
   output logic [2:0] rsp_token_class,
   output logic       rsp_run_last
);

   aol_pkg::bundle_type front_bundle, head_data;
   logic                push, pop, full, head_valid, accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   aol_front #(
      .DEPTH_BITS(DEPTH_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_ch),
      .last   (req_last),
      .bundle (front_bundle),
      .push   (push)
   );

   aol_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (front_bundle),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   aol_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_data       (head_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_char   (rsp_data_char),
      .rsp_token_class (rsp_token_class),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

// ----- rtl/asm_operand_lexer_top_chk.sv -----
`timescale 1ns / 1ps
`include "asm_operand_lexer_top_assert.svh"

module asm_operand_lexer_top_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_ch,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data_char,
   input logic [2:0] rsp_token_class,
   input logic       rsp_run_last
);

   logic [8:0]  req_payload;
   logic [13:0] rsp_payload;
   logic        req_wait, rsp_wait;
   logic        is_append, is_tok_end, is_stmt_end;
   logic        char_ok, class_ok;

   assign req_payload = {req_ch, req_last};
   assign rsp_payload = {rsp_kind, rsp_data_char, rsp_token_class, rsp_run_last};
   assign req_wait    = req_valid && req_stall;
   assign rsp_wait    = rsp_valid && rsp_stall;
   assign is_append   = rsp_kind == aol_pkg::KIND_APPEND;
   assign is_tok_end  = rsp_kind == aol_pkg::KIND_TOKEN_END;
   assign is_stmt_end = rsp_kind == aol_pkg::KIND_STMT_END;
   assign char_ok     = is_append || rsp_data_char == 8'd0;
   assign class_ok    = rsp_token_class <= aol_pkg::CLASS_OP &&
                        (is_tok_end || rsp_token_class == aol_pkg::CLASS_NONE);

   `AOL_ASSERT_IMPL(a_stmt_end_last, clock, reset, rsp_valid && is_stmt_end, rsp_run_last)
   `AOL_ASSERT_IMPL(a_char_only_append, clock, reset, rsp_valid, char_ok)
   `AOL_ASSERT_IMPL(a_class_legal, clock, reset, rsp_valid, class_ok)
   `AOL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_payload))
   `AOL_ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_payload))

endmodule

bind asm_operand_lexer_top asm_operand_lexer_top_chk u_chk (.*);
